// ===== design/lrw_pkg.sv =====
// Shared types and constants of the LDM-to-LDR trampoline rewriter.
package lrw_pkg;

  localparam logic [31:0] MatchMask  = 32'hFFF0_0000;
  localparam logic [31:0] MatchValue = 32'hE890_0000;
  localparam logic [31:0] LdrBase    = 32'hE590_0000;
  localparam logic [31:0] JumpWord   = 32'hE51F_F004;
  localparam logic [3:0]  BaseLimit  = 4'd13;
  localparam logic [31:0] AddrStep   = 32'd4;
  localparam logic [5:0]  OffStep    = 6'd4;

  // One matched instruction waiting for expansion.
  typedef struct packed {
    logic [3:0]  base;
    logic [15:0] reg_list;
    logic [31:0] addr;
  } lrw_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_HELD,
    ST_JUMP,
    ST_RET
  } lrw_state_e;

endpackage

// ===== design/ldm_to_ldr_rewriter_core.sv =====
// Top level of the LDM-to-LDR trampoline rewriter.
// Takes one input word per cycle while the queue is not full; words that do not match
// are dropped, and they too wait while the queue is full.
// A matching word with n listed registers yields n + 2 output words, one per cycle while
// the output is popped; a match taken while the sequencer is idle is first loaded into it.
// Reset clears the queue, the sequencer state and the output valid flag.
module ldm_to_ldr_rewriter_core #(
  parameter int FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] instr_word_i,
  input  logic [31:0] instr_addr_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_word_o,
  output logic        is_last_o
);
  import lrw_pkg::*;

  lrw_entry_t front_entry;
  lrw_entry_t head_entry;
  logic       fifo_push;
  logic       fifo_pop;
  logic       fifo_full;
  logic       fifo_empty;

  lrw_front u_front (
    .push_i       (push),
    .fifo_full_i  (fifo_full),
    .instr_word_i (instr_word_i),
    .instr_addr_i (instr_addr_i),
    .full_o       (full),
    .fifo_push_o  (fifo_push),
    .entry_o      (front_entry)
  );

  lrw_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .entry_i (front_entry),
    .pop_i   (fifo_pop),
    .entry_o (head_entry),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  lrw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (head_entry),
    .fifo_empty_i (fifo_empty),
    .fifo_pop_o   (fifo_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_word_o   (out_word_o),
    .is_last_o    (is_last_o)
  );

endmodule

// ===== design/lrw_front.sv =====
// Front end: accepts instruction words and forwards only matching LDMIA words.
module lrw_front (
  input  logic               push_i,
  input  logic               fifo_full_i,
  input  logic [31:0]        instr_word_i,
  input  logic [31:0]        instr_addr_i,
  output logic               full_o,
  output logic               fifo_push_o,
  output lrw_pkg::lrw_entry_t entry_o
);
  import lrw_pkg::*;

  logic       is_match;
  logic [3:0] base;

  assign base     = instr_word_i[19:16];
  assign is_match = ((instr_word_i & MatchMask) == MatchValue) && (base < BaseLimit);

  // Words that do not match are taken and dropped, but only while the queue is not full.
  assign full_o      = fifo_full_i;
  assign fifo_push_o = push_i && !fifo_full_i && is_match;

  assign entry_o.base     = base;
  assign entry_o.reg_list = instr_word_i[15:0];
  assign entry_o.addr     = instr_addr_i;

endmodule

// ===== design/lrw_fifo.sv =====
// Short queue of matched instructions between the front and back ends.
module lrw_fifo #(
  parameter int Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lrw_pkg::lrw_entry_t entry_i,
  input  logic                pop_i,
  output lrw_pkg::lrw_entry_t entry_o,
  output logic                full_o,
  output logic                empty_o
);
  import lrw_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  lrw_entry_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into a full queue");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q)) else $error("pointers differ on empty queue");

endmodule

// ===== design/lrw_back.sv =====
// Back end: expands one matched instruction into its trampoline words.
module lrw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrw_pkg::lrw_entry_t entry_i,
  input  logic                fifo_empty_i,
  output logic                fifo_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [31:0]         out_word_o,
  output logic                is_last_o
);
  import lrw_pkg::*;

  lrw_state_e  st_q, st_d;
  logic [3:0]  base_q, base_d;
  logic [15:0] rem_q, rem_d;
  logic        held_q, held_d;
  logic [5:0]  off_q, off_d;
  logic [5:0]  hoff_q, hoff_d;
  logic [31:0] addr_q, addr_d;
  logic        ov_q, ov_d;
  logic [31:0] ow_q, ow_d;
  logic        ol_q, ol_d;

  logic        slot_free;
  logic        take;
  logic        emit_valid;
  logic [31:0] emit_word;
  logic        emit_last;
  logic [3:0]  low_idx;
  logic [15:0] new_rem;
  logic [15:0] below_base;
  logic [5:0]  load_off;

  assign slot_free = !ov_q || pop_i;

  // Lowest register still to be loaded.
  always_comb begin
    low_idx = '0;
    for (int i = 15; i >= 0; i--) begin
      if (rem_q[i]) begin
        low_idx = 4'(i);
      end
    end
  end

  // Registers above a held base register still skip the slot that the base load owns.
  assign load_off = (held_q && (low_idx > base_q)) ? (off_q + OffStep) : off_q;

  assign take       = !fifo_empty_i &&
                      ((st_q == ST_IDLE) || ((st_q == ST_RET) && slot_free));
  assign fifo_pop_o = take;
  assign new_rem    = entry_i.reg_list & ~(16'd1 << entry_i.base);
  assign below_base = entry_i.reg_list & ((16'd1 << entry_i.base) - 16'd1);

  // Next state and datapath registers.
  always_comb begin
    st_d   = st_q;
    base_d = base_q;
    rem_d  = rem_q;
    held_d = held_q;
    off_d  = off_q;
    hoff_d = hoff_q;
    addr_d = addr_q;
    unique case (st_q)
      ST_IDLE: ;
      ST_LOAD: begin
        if (slot_free) begin
          rem_d = rem_q & (rem_q - 16'd1);
          off_d = off_q + OffStep;
          if (rem_d == '0) begin
            st_d = held_q ? ST_HELD : ST_JUMP;
          end
        end
      end
      ST_HELD: if (slot_free) st_d = ST_JUMP;
      ST_JUMP: if (slot_free) st_d = ST_RET;
      ST_RET:  if (slot_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
    if (take) begin
      // The base register keeps its offset slot but is loaded last.
      base_d = entry_i.base;
      addr_d = entry_i.addr;
      rem_d  = new_rem;
      held_d = entry_i.reg_list[entry_i.base];
      off_d  = '0;
      hoff_d = {4'($countones(below_base)), 2'b00};
      if (new_rem != '0) begin
        st_d = ST_LOAD;
      end else if (entry_i.reg_list[entry_i.base]) begin
        st_d = ST_HELD;
      end else begin
        st_d = ST_JUMP;
      end
    end
  end

  // Word produced in the current state.
  always_comb begin
    emit_valid = 1'b0;
    emit_word  = '0;
    emit_last  = 1'b0;
    unique case (st_q)
      ST_IDLE: ;
      ST_LOAD: begin
        emit_valid = 1'b1;
        emit_word  = LdrBase | {12'h000, base_q, low_idx, 6'b0, load_off};
      end
      ST_HELD: begin
        emit_valid = 1'b1;
        emit_word  = LdrBase | {12'h000, base_q, base_q, 6'b0, hoff_q};
      end
      ST_JUMP: begin
        emit_valid = 1'b1;
        emit_word  = JumpWord;
      end
      ST_RET: begin
        emit_valid = 1'b1;
        emit_word  = addr_q + AddrStep;
        emit_last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    ow_d = ow_q;
    ol_d = ol_q;
    if (slot_free) begin
      ov_d = emit_valid;
      ow_d = emit_word;
      ol_d = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    rem_q  <= rem_d;
    held_q <= held_d;
    off_q  <= off_d;
    hoff_q <= hoff_d;
    addr_q <= addr_d;
    ow_q   <= ow_d;
    ol_q   <= ol_d;
  end

  assign empty_o    = !ov_q;
  assign out_word_o = ow_q;
  assign is_last_o  = ol_q;

  a_load_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_LOAD) |-> (rem_q != '0)) else $error("load state with empty list");
  a_ret_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_RET) && slot_free) |=> (ov_q && ol_q)) else $error("return word not last");
  a_take_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop_o |-> !fifo_empty_i) else $error("pop from empty queue");
  a_jump_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_JUMP) && slot_free) |=> (st_q == ST_RET)) else $error("jump not followed");

endmodule

// ===== tb/ldm_to_ldr_rewriter_core_tb.sv =====
// Self-checking testbench of the LDM-to-LDR trampoline rewriter with directed and random words.
module ldm_to_ldr_rewriter_core_tb;
  import lrw_pkg::*;

  localparam int StallLimit = 2000;
  localparam int DrainCycles = 20;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } tramp_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] instr_word_i = '0;
  logic [31:0] instr_addr_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] out_word_o;
  logic        is_last_o;

  tramp_word_t expected_words[$];
  int          mismatches = 0;
  int          stall_cycles = 0;
  bit          quiet = 1'b0;

  ldm_to_ldr_rewriter_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .instr_word_i(instr_word_i),
    .instr_addr_i(instr_addr_i),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word_o),
    .is_last_o   (is_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Appends the trampoline that one accepted instruction word must produce.
  function automatic void predict_trampoline(input logic [31:0] w, input logic [31:0] a);
    logic [3:0]  base;
    logic [15:0] list;
    logic [11:0] off;
    logic [31:0] ldr;
    logic [31:0] held;
    logic        have_held;
    base = w[19:16];
    list = w[15:0];
    off = '0;
    held = '0;
    have_held = 1'b0;
    if ((w & MatchMask) != MatchValue || base >= BaseLimit) return;
    for (int r = 0; r < 16; r++) begin
      if (list[r]) begin
        ldr = LdrBase | {12'd0, base, 4'(r), off};
        // The load that overwrites the base register has to come after all others.
        if (4'(r) == base) begin
          held = ldr;
          have_held = 1'b1;
        end else begin
          expected_words.push_back('{word: ldr, last: 1'b0});
        end
        off = off + 12'd4;
      end
    end
    if (have_held) expected_words.push_back('{word: held, last: 1'b0});
    expected_words.push_back('{word: JumpWord, last: 1'b0});
    expected_words.push_back('{word: a + AddrStep, last: 1'b1});
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %08h expected %08h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= quiet || ($urandom_range(99) >= 23);
    end
  end

  // Predicts on each accepted input word and checks each accepted result word.
  always @(posedge clk_i) begin
    tramp_word_t exp_w;
    if (rst_ni) begin
      if (push && !full) predict_trampoline(instr_word_i, instr_addr_i);
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_word_o, '0);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_word_o !== exp_w.word) report_mismatch("out_word", out_word_o, exp_w.word);
          if (is_last_o !== exp_w.last) report_mismatch("is_last", 32'(is_last_o), 32'(exp_w.last));
        end
      end
      if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Leaves push high after acceptance so a following word can go out back to back.
  task automatic send_word(input logic [31:0] w, input logic [31:0] a);
    while (!quiet && $urandom_range(99) < 23) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    instr_word_i <= w;
    instr_addr_i <= a;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic test_match_extremes();
    send_word(32'hE890_0000, 32'h0000_0000);
    send_word(32'hE890_FFFF, 32'hFFFF_FFFC);
    send_word(32'hE89C_FFFF, 32'hFFFF_FFFF);
    send_word(32'hE894_AAAA, 32'h8000_0000);
    send_word(32'hE897_5555, 32'h7FFF_FFF8);
    send_word(32'hE892_0006, 32'h1234_5677);
  endtask

  task automatic test_base_and_pc_in_list();
    send_word(32'hE893_0018, 32'h0000_1000);
    send_word(32'hE895_0020, 32'h0000_2004);
    send_word(32'hE891_8000, 32'h0000_3008);
    send_word(32'hE89B_8801, 32'h0000_400C);
  endtask

  task automatic test_non_matching();
    send_word(32'hE89D_FFFF, 32'h0000_0010);
    send_word(32'hE89E_0001, 32'h0000_0014);
    send_word(32'hE89F_0001, 32'h0000_0018);
    send_word(32'h0890_0001, 32'h0000_001C);
    send_word(32'hE8B0_0001, 32'h0000_0020);
    send_word(32'hE8D0_0001, 32'h0000_0024);
    send_word(32'hE810_0001, 32'h0000_0028);
    send_word(32'hE880_0001, 32'h0000_002C);
    send_word(32'h0000_0000, 32'h0000_0030);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_words(input int count);
    logic [31:0] w;
    logic [15:0] list;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      case ($urandom_range(3))
        0: list = 16'($urandom);
        1: list = 16'($urandom) & 16'($urandom) & 16'($urandom);
        2: list = 16'($urandom) | 16'($urandom) | 16'($urandom);
        default: list = 16'(1 << $urandom_range(15));
      endcase
      if (pick < 75) begin
        w = {12'hE89, 4'($urandom_range(12)), list};
      end else if (pick < 85) begin
        w = {12'hE89, 4'($urandom_range(15, 13)), list};
      end else if (pick < 93) begin
        // Near miss: one bit of the condition and opcode fields is wrong.
        w = {12'hE89 ^ 12'(1 << $urandom_range(11)), 4'($urandom_range(12)), list};
      end else begin
        w = $urandom;
      end
      send_word(w, $urandom);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_match_extremes();
    test_base_and_pc_in_list();
    test_non_matching();
    quiet = 1'b1;
    test_random_words(40);
    quiet = 1'b0;
    test_random_words(110);
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
